// ===== hw/rtl/stepgen_pkg.sv =====
// ----------------------------------------------------------------------------
// stepgen_pkg
// Shared types and constants of the stepper step/direction generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stepgen_pkg;

  localparam int TICK_HZ_DEFAULT = 1000000;

  localparam int POS_W    = 32;
  localparam int SPEED_W  = 16;
  localparam int PERIOD_W = 20;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_SPEED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED     = 2'd2;

  localparam logic [SPEED_W-1:0] DEFAULT_SPEED_RST = 16'd1000;
  localparam logic [SPEED_W-1:0] MAX_SPEED_RST     = 16'd2000;

  localparam logic [2:0] MODE_TICK  = 3'd0;
  localparam logic [2:0] MODE_ABS   = 3'd1;
  localparam logic [2:0] MODE_REL   = 3'd2;
  localparam logic [2:0] MODE_ABORT = 3'd3;
  localparam logic [2:0] MODE_ZERO  = 3'd4;

  localparam logic [2:0] ST_NONE      = 3'd0;
  localparam logic [2:0] ST_DONE      = 3'd1;
  localparam logic [2:0] ST_LIM_START = 3'd2;
  localparam logic [2:0] ST_LIM_END   = 3'd3;
  localparam logic [2:0] ST_ABORTED   = 3'd4;
  localparam logic [2:0] ST_REJECTED  = 3'd5;

  typedef enum logic [0:0] {
    S_IDLE,
    S_DIV
  } sg_state_t;

  typedef struct packed {
    logic exec_item;
    logic load_move;
    logic div_start;
    logic first_step;
    logic load_out;
  } sg_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
  } sg_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/stepgen_div.sv =====
// ----------------------------------------------------------------------------
// stepgen_div
// Restoring divider, one quotient bit per cycle: TICK_HZ / divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stepgen_div #(
  parameter int TICK_HZ = stepgen_pkg::TICK_HZ_DEFAULT,
  parameter int DW      = $clog2(TICK_HZ + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [stepgen_pkg::SPEED_W-1:0] divisor,
  output logic                            done,
  output logic [DW-1:0]                   quotient
);
  import stepgen_pkg::*;

  localparam int CW = $clog2(DW + 1);
  localparam logic [DW-1:0] DIVIDEND = DW'(TICK_HZ);

  logic [CW-1:0]      cnt;
  logic [DW-1:0]      dvd;
  logic [SPEED_W-1:0] dvs;
  logic [SPEED_W-1:0] rem;
  logic [SPEED_W:0]   trial;
  logic               fits;

  assign trial = {rem, dvd[DW-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == CW'(1));
      if (start) begin
        cnt <= CW'(DW);
      end else if (cnt != '0) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= DIVIDEND;
      dvs      <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (cnt != '0) begin
      dvd      <= dvd << 1;
      rem      <= fits ? SPEED_W'(trial - {1'b0, dvs}) : SPEED_W'(trial);
      quotient <= {quotient[DW-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/stepgen_datapath.sv =====
// ----------------------------------------------------------------------------
// stepgen_datapath
// Config registers, axis state, step logic, speed clamp and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stepgen_datapath #(
  parameter int TICK_HZ = stepgen_pkg::TICK_HZ_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  stepgen_pkg::sg_cmd_t               cmd,
  output stepgen_pkg::sg_status_t            stat,
  input  logic                               cfg_we,
  input  logic [stepgen_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [stepgen_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [2:0]                         mode,
  input  logic signed [31:0]                 target_value,
  input  logic [15:0]                        speed_request,
  input  logic                               limit_start,
  input  logic                               limit_end,
  output logic                               step_pulse,
  output logic                               direction,
  output logic signed [31:0]                 position,
  output logic                               moving,
  output logic [2:0]                         status
);
  import stepgen_pkg::*;

  localparam int DW = $clog2(TICK_HZ + 1);
  localparam int XW = (DW > PERIOD_W) ? DW : PERIOD_W;

  logic               enabled;
  logic [SPEED_W-1:0] default_speed;
  logic [SPEED_W-1:0] max_speed;

  logic [POS_W-1:0]    pos, pos_next;
  logic [POS_W-1:0]    target_position, target_position_next;
  logic [POS_W-1:0]    steps_left, steps_left_next;
  logic [PERIOD_W-1:0] step_period, step_period_next;
  logic [PERIOD_W-1:0] tick_countdown, tick_countdown_next;
  logic                dir_forward, dir_forward_next;
  logic                busy, busy_next;
  logic                lim_s_hold, lim_e_hold;

  logic [POS_W-1:0]    target_calc, diff;
  logic                is_move;
  logic [SPEED_W-1:0]  speed_base, speed_top, speed_lo, speed_calc;
  logic                div_done;
  logic [DW-1:0]       quo;
  logic [XW-1:0]       quo_x;
  logic [PERIOD_W-1:0] period_calc;

  logic                do_try, lim_s, lim_e;
  logic [POS_W-1:0]    sl_dec;
  logic                pulse_next;
  logic [2:0]          status_next;

  assign target_calc = (mode == MODE_REL) ? pos + $unsigned(target_value)
                                          : $unsigned(target_value);
  assign diff        = target_calc - pos;
  assign is_move     = (mode == MODE_ABS) || (mode == MODE_REL);

  assign speed_base = (speed_request != '0) ? speed_request : default_speed;
  assign speed_top  = (max_speed != '0) ? max_speed : SPEED_W'(1);
  assign speed_lo   = (speed_base != '0) ? speed_base : SPEED_W'(1);
  assign speed_calc = (speed_lo > speed_top) ? speed_top : speed_lo;

  assign stat = '{need_div: is_move && enabled && !busy && (diff != '0),
                  div_done: div_done};

  stepgen_div #(
    .TICK_HZ (TICK_HZ),
    .DW      (DW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .divisor  (speed_calc),
    .done     (div_done),
    .quotient (quo)
  );

  assign quo_x = XW'(quo);
  always_comb begin
    if (quo_x > XW'(PERIOD_MAX)) begin
      period_calc = PERIOD_MAX;
    end else if (quo_x == '0) begin
      period_calc = PERIOD_W'(1);
    end else begin
      period_calc = PERIOD_W'(quo_x);
    end
  end

  assign lim_s  = cmd.first_step ? lim_s_hold : limit_start;
  assign lim_e  = cmd.first_step ? lim_e_hold : limit_end;
  assign sl_dec = steps_left - POS_W'(1);

  always_comb begin
    pos_next             = pos;
    target_position_next = target_position;
    steps_left_next      = steps_left;
    step_period_next     = step_period;
    tick_countdown_next  = tick_countdown;
    dir_forward_next     = dir_forward;
    busy_next            = busy;
    pulse_next           = 1'b0;
    status_next          = ST_NONE;
    do_try               = 1'b0;

    if (cmd.exec_item) begin
      unique case (mode)
        MODE_TICK: begin
          if (busy) begin
            if (tick_countdown > PERIOD_W'(1)) begin
              tick_countdown_next = tick_countdown - PERIOD_W'(1);
            end else begin
              do_try = 1'b1;
            end
          end
        end
        MODE_ABS, MODE_REL: begin
          if (!enabled || busy) begin
            status_next = ST_REJECTED;
          end else begin
            target_position_next = target_calc;
            status_next          = ST_DONE;
          end
        end
        MODE_ABORT: begin
          if (busy) begin
            busy_next   = 1'b0;
            status_next = ST_ABORTED;
          end
        end
        MODE_ZERO: begin
          pos_next             = '0;
          target_position_next = '0;
        end
        default: ;
      endcase
    end

    if (cmd.load_move) begin
      target_position_next = target_calc;
      dir_forward_next     = !diff[POS_W-1];
      steps_left_next      = diff[POS_W-1] ? (POS_W'(0) - diff) : diff;
    end

    if (cmd.first_step) begin
      step_period_next = period_calc;
      busy_next        = 1'b1;
      do_try           = 1'b1;
    end

    if (do_try) begin
      if (!dir_forward && lim_s) begin
        busy_next   = 1'b0;
        status_next = ST_LIM_START;
      end else if (dir_forward && lim_e) begin
        busy_next   = 1'b0;
        status_next = ST_LIM_END;
      end else begin
        pulse_next          = 1'b1;
        pos_next            = dir_forward ? pos + POS_W'(1) : pos - POS_W'(1);
        steps_left_next     = sl_dec;
        tick_countdown_next = cmd.first_step ? period_calc : step_period;
        if (sl_dec == '0) begin
          busy_next   = 1'b0;
          status_next = ST_DONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled         <= 1'b0;
      default_speed   <= DEFAULT_SPEED_RST;
      max_speed       <= MAX_SPEED_RST;
      pos             <= '0;
      target_position <= '0;
      steps_left      <= '0;
      step_period     <= '0;
      tick_countdown  <= '0;
      dir_forward     <= 1'b0;
      busy            <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ENABLED:       enabled       <= cfg_data[0];
          CFG_DEFAULT_SPEED: default_speed <= cfg_data;
          CFG_MAX_SPEED:     max_speed     <= cfg_data;
          default: ;
        endcase
      end
      pos             <= pos_next;
      target_position <= target_position_next;
      steps_left      <= steps_left_next;
      step_period     <= step_period_next;
      tick_countdown  <= tick_countdown_next;
      dir_forward     <= dir_forward_next;
      busy            <= busy_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_move) begin
      lim_s_hold <= limit_start;
      lim_e_hold <= limit_end;
    end
    if (cmd.load_out) begin
      step_pulse <= pulse_next;
      direction  <= dir_forward_next;
      position   <= pos_next;
      moving     <= busy_next;
      status     <= status_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/stepgen_ctrl.sv =====
// ----------------------------------------------------------------------------
// stepgen_ctrl
// Controller: input/output handshake and sequencing of divider moves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stepgen_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  logic                    out_stall,
  input  stepgen_pkg::sg_status_t stat,
  output stepgen_pkg::sg_cmd_t    cmd
);
  import stepgen_pkg::*;

  sg_state_t state, state_next;
  logic      accept;
  logic      out_valid_next;

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (stat.need_div) begin
            cmd.load_move = 1'b1;
            cmd.div_start = 1'b1;
            state_next    = S_DIV;
          end else begin
            cmd.exec_item = 1'b1;
            cmd.load_out  = 1'b1;
          end
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.first_step = 1'b1;
          cmd.load_out   = 1'b1;
          state_next     = S_IDLE;
        end
      end
    endcase
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  assert property (@(posedge clk) disable iff (rst) (state == S_DIV) |-> in_stall)
    else $error("item taken while divider busy");

  assert property (@(posedge clk) disable iff (rst)
    (accept && stat.need_div) |=> (state == S_DIV))
    else $error("move did not start division");

  assert property (@(posedge clk) disable iff (rst) stat.div_done |-> (state == S_DIV))
    else $error("divider done outside of move");

  assert property (@(posedge clk) disable iff (rst)
    !(cmd.load_out && out_valid && out_stall))
    else $error("result overwritten before taken");

endmodule

`default_nettype wire

// ===== hw/rtl/stepper_step_dir_generator.sv =====
// ----------------------------------------------------------------------------
// stepper_step_dir_generator
// Step/direction generator for one stepper axis with two limit switches.
// ----------------------------------------------------------------------------
// Tick, abort, zero, rejected and zero-length move items: accepted each
// cycle unless output stalls, result registered the cycle after acceptance.
// Moves of nonzero length: after acceptance the one-bit-per-cycle period
// divider computes the step period, then the first step (or limit stop) and
// its result are registered; input stalls meanwhile.
// Reset (synchronous): axis state cleared, enabled 0, speeds 1000 / 2000.
`timescale 1ns / 1ps
`default_nettype none

module stepper_step_dir_generator #(
  parameter int TICK_HZ = stepgen_pkg::TICK_HZ_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [stepgen_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [stepgen_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [2:0]                         mode,
  input  logic signed [31:0]                 target_value,
  input  logic [15:0]                        speed_request,
  input  logic                               limit_start,
  input  logic                               limit_end,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               step_pulse,
  output logic                               direction,
  output logic signed [31:0]                 position,
  output logic                               moving,
  output logic [2:0]                         status
);
  import stepgen_pkg::*;

  sg_cmd_t    cmd;
  sg_status_t stat;

  stepgen_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  stepgen_datapath #(
    .TICK_HZ (TICK_HZ)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mode          (mode),
    .target_value  (target_value),
    .speed_request (speed_request),
    .limit_start   (limit_start),
    .limit_end     (limit_end),
    .step_pulse    (step_pulse),
    .direction     (direction),
    .position      (position),
    .moving        (moving),
    .status        (status)
  );

endmodule

`default_nettype wire

// ===== tb/stepper_step_dir_generator_tb.sv =====
// ----------------------------------------------------------------------------
// stepper_step_dir_generator_tb
// Self-checking bench for the stepper step/direction generator. A directed
// table covers rejects, zero-length moves, limit stops, wrap, aborts, zeroing
// and disabling mid-move. Random phases follow under several register
// settings, with sender gaps, receiver stalls and one long output hold-off.
// Each result is compared against an in-bench model of the axis or a fixed expected value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stepper_step_dir_generator_tb;
  import stepgen_pkg::*;

  localparam int unsigned AXIS_TICK_HZ = TICK_HZ_DEFAULT;
  localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [2:0] MODE_UNUSED_HI = 3'd7;
  localparam int unsigned NUM_PHASES = 6;
  localparam int unsigned HOLD_CYCLES = 60;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] tval;
    logic [15:0] sreq;
    logic        ls;
    logic        le;
  } stim_t;

  typedef struct packed {
    logic        pulse;
    logic        dir;
    logic [31:0] pos;
    logic        moving;
    logic [2:0]  status;
  } axis_out_t;

  typedef struct {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    stim_t                 s;
    int unsigned           reps;
    logic                  known;
    axis_out_t             want;
  } plan_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [2:0]            mode;
  logic signed [31:0]    target_value;
  logic [15:0]           speed_request;
  logic                  limit_start;
  logic                  limit_end;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  step_pulse;
  logic                  direction;
  logic signed [31:0]    position;
  logic                  moving;
  logic [2:0]            status;

  // axis model state and register copies
  logic [31:0] ax_pos, ax_tgt, ax_left;
  logic [19:0] ax_period, ax_count;
  logic        ax_fwd, ax_busy;
  logic        cf_en;
  logic [15:0] cf_dflt, cf_max;

  axis_out_t   expected_q[$];
  plan_row_t   plan_q[$];
  axis_out_t   rx_want, rx_got;
  int unsigned snd_pct, rcv_pct;
  int unsigned hold_reqs, hold_seen, hold_left;
  int unsigned fails, n_items, n_results, n_steps;
  int unsigned status_seen[8];

  int unsigned ph_items[NUM_PHASES] = '{120, 100, 100, 120, 40, 70};
  int unsigned ph_snd[NUM_PHASES]   = '{0, 80, 0, 35, 35, 0};
  int unsigned ph_rcv[NUM_PHASES]   = '{0, 0, 80, 35, 35, 0};
  logic        ph_en[NUM_PHASES]    = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
  logic [15:0] ph_dflt[NUM_PHASES]  = '{16'hFFFF, 16'd40000, 16'd25000, 16'd50000,
                                        16'd1, 16'hFFFF};
  logic [15:0] ph_max[NUM_PHASES]   = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd30000,
                                        16'd1, 16'd30000};

  stepper_step_dir_generator i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mode          (mode),
    .target_value  (target_value),
    .speed_request (speed_request),
    .limit_start   (limit_start),
    .limit_end     (limit_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .step_pulse    (step_pulse),
    .direction     (direction),
    .position      (position),
    .moving        (moving),
    .status        (status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic axis_out_t advance_axis(input stim_t s);
    axis_out_t   r;
    logic [31:0] diff, spd, top, q;
    logic        try_it;
    r = '0;
    try_it = 1'b0;
    case (s.mode)
      MODE_TICK: begin
        if (ax_busy) begin
          if (ax_count > 20'd1) ax_count = ax_count - 20'd1;
          else try_it = 1'b1;
        end
      end
      MODE_ABS, MODE_REL: begin
        if (!cf_en || ax_busy) begin
          r.status = ST_REJECTED;
        end else begin
          ax_tgt = (s.mode == MODE_REL) ? ax_pos + s.tval : s.tval;
          diff = ax_tgt - ax_pos;
          if (diff == 0) begin
            r.status = ST_DONE;
          end else begin
            spd = (s.sreq != 0) ? 32'(s.sreq) : 32'(cf_dflt);
            top = (cf_max != 0) ? 32'(cf_max) : 32'd1;
            if (spd < 1) spd = 1;
            if (spd > top) spd = top;
            q = AXIS_TICK_HZ / spd;
            if (q > 32'(PERIOD_MAX)) q = 32'(PERIOD_MAX);
            if (q == 0) q = 1;
            ax_period = q[19:0];
            ax_fwd = ~diff[31];
            ax_left = ax_fwd ? diff : -diff;
            ax_busy = 1'b1;
            try_it = 1'b1;
          end
        end
      end
      MODE_ABORT: begin
        if (ax_busy) begin
          ax_busy = 1'b0;
          r.status = ST_ABORTED;
        end
      end
      MODE_ZERO: begin
        ax_pos = '0;
        ax_tgt = '0;
      end
      default: ;
    endcase
    if (try_it) begin
      if (!ax_fwd && s.ls) begin
        ax_busy = 1'b0;
        r.status = ST_LIM_START;
      end else if (ax_fwd && s.le) begin
        ax_busy = 1'b0;
        r.status = ST_LIM_END;
      end else begin
        r.pulse = 1'b1;
        ax_pos = ax_fwd ? ax_pos + 1 : ax_pos - 1;
        ax_left = ax_left - 1;
        ax_count = ax_period;
        if (ax_left == 0) begin
          ax_busy = 1'b0;
          r.status = ST_DONE;
        end
      end
    end
    r.dir = ax_fwd;
    r.pos = ax_pos;
    r.moving = ax_busy;
    return r;
  endfunction

  function automatic void add_item(input logic [2:0] m, input logic [31:0] tv,
                                   input logic [15:0] sr, input logic ls, input logic le,
                                   input int unsigned reps);
    plan_row_t row;
    row = '{is_cfg: 1'b0, idx: '0, data: '0, s: {m, tv, sr, ls, le}, reps: reps,
            known: 1'b0, want: '0};
    plan_q.push_back(row);
  endfunction

  function automatic void add_known(input logic [2:0] m, input logic [31:0] tv,
                                    input logic [15:0] sr, input logic ls, input logic le,
                                    input axis_out_t want);
    plan_row_t row;
    row = '{is_cfg: 1'b0, idx: '0, data: '0, s: {m, tv, sr, ls, le}, reps: 1,
            known: 1'b1, want: want};
    plan_q.push_back(row);
  endfunction

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
    plan_row_t row;
    row = '{is_cfg: 1'b1, idx: idx, data: val, s: '0, reps: 0, known: 1'b0, want: '0};
    plan_q.push_back(row);
  endfunction

  function automatic stim_t pick_item();
    stim_t       s;
    int unsigned r;
    logic [31:0] delta;
    r = $urandom_range(99);
    delta = $urandom_range(12, 1);
    if ($urandom_range(1)) delta = -delta;
    s.mode = MODE_TICK;
    s.tval = $urandom;
    s.sreq = 16'($urandom);
    s.ls = ($urandom_range(99) < 8);
    s.le = ($urandom_range(99) < 8);
    if (ax_busy) begin
      if (r < 4) s.mode = MODE_ABORT;
      else if (r < 7) s.mode = MODE_ZERO;
      else if (r < 11) s.mode = 3'($urandom_range(MODE_REL, MODE_ABS));
      else if (r < 13) s.mode = 3'($urandom_range(MODE_UNUSED_HI, MODE_UNUSED_LO));
    end else if (r < 60) begin
      s.mode = 3'($urandom_range(MODE_REL, MODE_ABS));
      r = $urandom_range(99);
      if (r < 45) s.sreq = '0;
      else if (r < 85) s.sreq = 16'($urandom_range(65535, 8000));
      r = $urandom_range(99);
      if (r < 15) s.tval = (s.mode == MODE_REL) ? 32'd0 : ax_pos;
      else if (r < 85) s.tval = (s.mode == MODE_REL) ? delta : ax_pos + delta;
    end else if (r < 80) begin
      s.mode = MODE_TICK;
    end else if (r < 86) begin
      s.mode = MODE_ABORT;
    end else if (r < 92) begin
      s.mode = MODE_ZERO;
    end else begin
      s.mode = 3'($urandom_range(MODE_UNUSED_HI, MODE_UNUSED_LO));
    end
    return s;
  endfunction

  task automatic send_item(input stim_t s, input logic known, input axis_out_t want);
    axis_out_t r;
    while ($urandom_range(99) < snd_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= s.mode;
    target_value <= s.tval;
    speed_request <= s.sreq;
    limit_start <= s.ls;
    limit_end <= s.le;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = advance_axis(s);
    expected_q.push_back(known ? want : r);
    n_items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_ENABLED:       cf_en = val[0];
      CFG_DEFAULT_SPEED: cf_dflt = val;
      CFG_MAX_SPEED:     cf_max = val;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // result checker and output stall driver
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      rx_got = {step_pulse, direction, position, moving, status};
      n_results++;
      n_steps += rx_got.pulse;
      status_seen[rx_got.status]++;
      if (expected_q.size() == 0) begin
        $error("unexpected result: status %0d position %0d", rx_got.status,
               $signed(rx_got.pos));
        fails++;
      end else begin
        rx_want = expected_q.pop_front();
        if (rx_got.pulse !== rx_want.pulse) begin
          $error("step_pulse: expected %0d, got %0d", rx_want.pulse, rx_got.pulse);
          fails++;
        end
        if (rx_got.dir !== rx_want.dir) begin
          $error("direction: expected %0d, got %0d", rx_want.dir, rx_got.dir);
          fails++;
        end
        if (rx_got.pos !== rx_want.pos) begin
          $error("position: expected %0d, got %0d", $signed(rx_want.pos),
                 $signed(rx_got.pos));
          fails++;
        end
        if (rx_got.moving !== rx_want.moving) begin
          $error("moving: expected %0d, got %0d", rx_want.moving, rx_got.moving);
          fails++;
        end
        if (rx_got.status !== rx_want.status) begin
          $error("status: expected %0d, got %0d", rx_want.status, rx_got.status);
          fails++;
        end
      end
    end
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_pct);
    end
  end

  initial begin
    int unsigned p, k;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_ENABLED;
    cfg_data <= '0;
    in_valid <= 1'b0;
    mode <= MODE_TICK;
    target_value <= '0;
    speed_request <= '0;
    limit_start <= 1'b0;
    limit_end <= 1'b0;
    ax_pos = '0;
    ax_tgt = '0;
    ax_left = '0;
    ax_period = '0;
    ax_count = '0;
    ax_fwd = 1'b0;
    ax_busy = 1'b0;
    cf_en = 1'b0;
    cf_dflt = DEFAULT_SPEED_RST;
    cf_max = MAX_SPEED_RST;
    snd_pct = 0;
    rcv_pct = 0;
    hold_reqs = 0;
    hold_seen = 0;
    hold_left = 0;
    fails = 0;
    n_items = 0;
    n_results = 0;
    n_steps = 0;
    foreach (status_seen[i]) status_seen[i] = 0;

    add_known(MODE_ABS, 32'h7FFF_FFFF, 16'hFFFF, 1'b1, 1'b1,
              {1'b0, 1'b0, 32'd0, 1'b0, ST_REJECTED});
    add_known(MODE_ABORT, 32'd0, 16'd0, 1'b0, 1'b0, {1'b0, 1'b0, 32'd0, 1'b0, ST_NONE});
    add_known(MODE_UNUSED_HI, 32'h8000_0000, 16'd0, 1'b0, 1'b0,
              {1'b0, 1'b0, 32'd0, 1'b0, ST_NONE});
    add_known(MODE_ZERO, 32'hFFFF_FFFF, 16'd0, 1'b1, 1'b1,
              {1'b0, 1'b0, 32'd0, 1'b0, ST_NONE});
    add_cfg(CFG_ENABLED, 16'd1);
    add_known(MODE_REL, 32'd0, 16'd500, 1'b0, 1'b0, {1'b0, 1'b0, 32'd0, 1'b0, ST_DONE});
    add_cfg(CFG_MAX_SPEED, 16'hFFFF);
    add_cfg(CFG_DEFAULT_SPEED, 16'hFFFF);
    add_item(MODE_REL, 32'd3, 16'hFFFF, 1'b0, 1'b0, 1);
    add_item(MODE_ZERO, 32'd0, 16'd0, 1'b0, 1'b0, 1);
    add_item(MODE_REL, 32'd5, 16'd0, 1'b0, 1'b0, 1);
    add_item(MODE_TICK, 32'd0, 16'd0, 1'b1, 1'b1, 2);
    add_item(MODE_ABORT, 32'd0, 16'd0, 1'b0, 1'b0, 1);
    add_item(MODE_REL, 32'd1, 16'd0, 1'b1, 1'b0, 1);
    add_item(MODE_REL, 32'hFFFF_FFFF, 16'd0, 1'b0, 1'b1, 1);
    add_item(MODE_ABS, 32'hFFFF_FF9C, 16'd0, 1'b1, 1'b0, 1);
    add_item(MODE_REL, 32'd7, 16'd1, 1'b0, 1'b1, 1);
    add_item(MODE_ABS, 32'h7FFF_FFFF, 16'hFFFF, 1'b0, 1'b0, 1);
    add_item(MODE_ABORT, 32'd0, 16'd0, 1'b0, 1'b0, 1);
    add_cfg(CFG_MAX_SPEED, 16'd0);
    add_item(MODE_REL, 32'd1000, 16'hFFFF, 1'b0, 1'b0, 1);
    add_cfg(CFG_ENABLED, 16'd0);
    add_item(MODE_TICK, 32'd0, 16'd0, 1'b0, 1'b0, 1);
    add_item(MODE_ABS, 32'd5, 16'd0, 1'b0, 1'b0, 1);
    add_item(MODE_ABORT, 32'd0, 16'd0, 1'b0, 1'b0, 1);
    add_cfg(CFG_ENABLED, 16'd1);
    add_cfg(CFG_DEFAULT_SPEED, 16'd0);
    add_cfg(CFG_MAX_SPEED, 16'hFFFF);
    add_item(MODE_REL, 32'h8000_0000, 16'd0, 1'b0, 1'b0, 1);
    add_item(MODE_UNUSED_LO, 32'd0, 16'd0, 1'b0, 1'b0, 1);
    add_item(MODE_ABORT, 32'd0, 16'd0, 1'b0, 1'b0, 1);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan_q[i]) begin
      if (plan_q[i].is_cfg) begin
        drain();
        write_reg(plan_q[i].idx, plan_q[i].data);
      end else begin
        repeat (plan_q[i].reps) send_item(plan_q[i].s, plan_q[i].known, plan_q[i].want);
      end
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      drain();
      write_reg(CFG_ENABLED, 16'(ph_en[p]));
      write_reg(CFG_DEFAULT_SPEED, ph_dflt[p]);
      write_reg(CFG_MAX_SPEED, ph_max[p]);
      snd_pct = ph_snd[p];
      rcv_pct = ph_rcv[p];
      for (k = 0; k < ph_items[p]; k++) begin
        if (p == 0 && k == 30) hold_reqs++;
        send_item(pick_item(), 1'b0, '0);
      end
    end

    drain();
    repeat (50) @(posedge clk);
    $display("Covered %0d items in %0d results: %0d steps, %0d moves done, %0d limit stops",
             n_items, n_results, n_steps, status_seen[ST_DONE],
             status_seen[ST_LIM_START] + status_seen[ST_LIM_END]);
    $display("Also %0d aborts and %0d rejects over %0d register settings with stalls",
             status_seen[ST_ABORTED], status_seen[ST_REJECTED], NUM_PHASES);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
